// ===== sv/dqp_pkg.sv =====
// ---------------------------------------------------------------------------
// dqp_pkg
// Shared types, constants and helper functions of the decimal literal to
// qfp32 parser: character codes, state and error codes, the command and
// status groups between controller and datapath, and the power-of-ten table.
// ---------------------------------------------------------------------------
`default_nettype none

package dqp_pkg;

   // Most digits that one part of a literal may hold.
   localparam int MAX_DIGITS = 9;

   // Widths of the accumulators, digit counters and the rounding division.
   localparam int ACC_W   = 30;
   localparam int CNT_W   = 4;
   localparam int QUO_W   = 25;
   localparam int NUM_W   = ACC_W + QUO_W;
   localparam int STEP_W  = 5;
   localparam int MANT_W  = 32;

   // An integer part at or above this value does not fit the format.
   localparam logic [ACC_W-1:0] INT_LIMIT = ACC_W'(1) << 29;

   // Character codes of the grammar.
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_POINT = 8'h2E;

   // Error codes of a result word.
   typedef enum logic [1:0] {
      ERR_NONE = 2'd0,
      ERR_INT  = 2'd1,
      ERR_FRAC = 2'd2
   } err_type;

   // Controller states.
   typedef enum logic [2:0] {
      ST_START,
      ST_INT,
      ST_FRAC,
      ST_SETUP,
      ST_DIVIDE,
      ST_PUBLISH
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic add_int;
      logic add_frac;
      logic set_sign;
      logic finish;
      logic setup;
      logic step;
      logic load_out;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic is_digit;
      logic is_minus;
      logic is_point;
      logic div_last;
      logic out_free;
   } status_type;

   // Ten to the power n; codes beyond the table give one.
   function automatic logic [ACC_W-1:0] pow10(input logic [CNT_W-1:0] n);
      logic [ACC_W-1:0] p;
      unique case (n)
         4'd0:    p = ACC_W'(1);
         4'd1:    p = ACC_W'(10);
         4'd2:    p = ACC_W'(100);
         4'd3:    p = ACC_W'(1000);
         4'd4:    p = ACC_W'(10000);
         4'd5:    p = ACC_W'(100000);
         4'd6:    p = ACC_W'(1000000);
         4'd7:    p = ACC_W'(10000000);
         4'd8:    p = ACC_W'(100000000);
         4'd9:    p = ACC_W'(1000000000);
         default: p = ACC_W'(1);
      endcase
      return p;
   endfunction

   // Number of significant bits of an accumulator value.
   function automatic logic [STEP_W-1:0] bit_len(input logic [ACC_W-1:0] v);
      logic [STEP_W-1:0] n;
      n = '0;
      for (int i = 0; i < ACC_W; i++) begin
         if (v[i]) begin
            n = STEP_W'(i + 1);
         end
      end
      return n;
   endfunction

endpackage

`default_nettype wire

// ===== sv/dqp_ctrl.sv =====
// ---------------------------------------------------------------------------
// dqp_ctrl
// Controller of the parser: follows the grammar of the literal, then walks
// the datapath through setup, the rounding division and the result load.
// ---------------------------------------------------------------------------
`default_nettype none

module dqp_ctrl (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire dqp_pkg::status_type status,
   output dqp_pkg::cmd_type        cmd
);
   import dqp_pkg::*;

   state_type state_ff;
   state_type state_in;
   logic      accept;

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_START;
      end else begin
         state_ff <= state_in;
      end
   end

   // Characters are taken only while the literal is being parsed.
   assign req_stall = !(state_ff == ST_START || state_ff == ST_INT ||
                        state_ff == ST_FRAC);
   assign accept    = req_valid && !req_stall;

   // Next state and commands.
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_START: begin
            if (accept) begin
               if (status.is_minus) begin
                  cmd.set_sign = 1'b1;
                  state_in     = ST_INT;
               end else if (status.is_digit) begin
                  cmd.add_int = 1'b1;
                  state_in    = ST_INT;
               end else if (status.is_point) begin
                  state_in = ST_FRAC;
               end else begin
                  cmd.finish = 1'b1;
                  state_in   = ST_SETUP;
               end
            end
         end
         ST_INT: begin
            if (accept) begin
               if (status.is_digit) begin
                  cmd.add_int = 1'b1;
               end else if (status.is_point) begin
                  state_in = ST_FRAC;
               end else begin
                  cmd.finish = 1'b1;
                  state_in   = ST_SETUP;
               end
            end
         end
         ST_FRAC: begin
            if (accept) begin
               if (status.is_digit) begin
                  cmd.add_frac = 1'b1;
               end else begin
                  cmd.finish = 1'b1;
                  state_in   = ST_SETUP;
               end
            end
         end
         ST_SETUP: begin
            cmd.setup = 1'b1;
            state_in  = ST_DIVIDE;
         end
         ST_DIVIDE: begin
            cmd.step = 1'b1;
            if (status.div_last) begin
               state_in = ST_PUBLISH;
            end
         end
         ST_PUBLISH: begin
            if (status.out_free) begin
               cmd.load_out = 1'b1;
               state_in     = ST_START;
            end
         end
         default: begin
            state_in = ST_START;
         end
      endcase
   end

endmodule

`default_nettype wire

// ===== sv/dqp_dpath.sv =====
// ---------------------------------------------------------------------------
// dqp_dpath
// Datapath of the parser: digit accumulators, the snapshot of a finished
// literal, exponent and alignment, a restoring divider that rounds the
// fraction, and the result register.
// ---------------------------------------------------------------------------
`default_nettype none

module dqp_dpath (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic [7:0]          req_ch,
   input  wire dqp_pkg::cmd_type    cmd,
   output dqp_pkg::status_type      status,
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output logic                     rsp_negative,
   output logic [1:0]               rsp_byte_exponent,
   output logic [31:0]              rsp_mantissa,
   output logic [1:0]               rsp_error_code
);
   import dqp_pkg::*;

   // Literal accumulators.
   logic             sign_ff,     sign_in;
   logic [ACC_W-1:0] int_acc_ff,  int_acc_in;
   logic [CNT_W-1:0] int_cnt_ff,  int_cnt_in;
   logic [ACC_W-1:0] frac_acc_ff, frac_acc_in;
   logic [CNT_W-1:0] frac_cnt_ff, frac_cnt_in;

   // Snapshot of a finished literal.
   logic             w_sign_ff;
   logic [ACC_W-1:0] w_int_ff;
   logic [ACC_W-1:0] w_frac_ff;
   logic [CNT_W-1:0] w_fcnt_ff;
   err_type          w_err_ff;
   err_type          err_calc;

   // Division and alignment.
   logic [1:0]        expo_ff;
   logic [MANT_W-1:0] base_ff;
   logic [ACC_W-1:0]  div_ff;
   logic [ACC_W-1:0]  rem_ff, rem_in;
   logic [QUO_W-1:0]  low_ff, low_in;
   logic [STEP_W-1:0] step_ff;

   // Result register.
   logic              out_valid_ff;
   logic              out_neg_ff;
   logic [1:0]        out_expo_ff;
   logic [MANT_W-1:0] out_mant_ff;
   err_type           out_err_ff;

   logic [3:0]        digit_val;
   logic [STEP_W-1:0] blen;
   logic [STEP_W:0]   expo_sum;
   logic [1:0]        expo_calc;
   logic [STEP_W-1:0] shamt;
   logic [ACC_W-1:0]  div_calc;
   logic [NUM_W-1:0]  num_calc;
   logic [ACC_W:0]    rem_sh;
   logic [ACC_W:0]    rem_diff;
   logic              rem_ge;

   // Character classes.
   assign digit_val       = req_ch[3:0];
   assign status.is_digit = (req_ch >= CH_ZERO) && (req_ch <= CH_NINE);
   assign status.is_minus = (req_ch == CH_MINUS);
   assign status.is_point = (req_ch == CH_POINT);
   assign status.div_last = (step_ff == STEP_W'(QUO_W - 1));
   assign status.out_free = !out_valid_ff || !rsp_stall;

   // Digit accumulation; a part that is already full only saturates its count.
   always_comb begin
      sign_in     = sign_ff;
      int_acc_in  = int_acc_ff;
      int_cnt_in  = int_cnt_ff;
      frac_acc_in = frac_acc_ff;
      frac_cnt_in = frac_cnt_ff;
      if (cmd.finish) begin
         sign_in     = 1'b0;
         int_acc_in  = '0;
         int_cnt_in  = '0;
         frac_acc_in = '0;
         frac_cnt_in = '0;
      end else begin
         if (cmd.set_sign) begin
            sign_in = 1'b1;
         end
         if (cmd.add_int) begin
            if (int_cnt_ff < CNT_W'(MAX_DIGITS)) begin
               int_acc_in = (int_acc_ff << 3) + (int_acc_ff << 1) + ACC_W'(digit_val);
               int_cnt_in = int_cnt_ff + CNT_W'(1);
            end else begin
               int_cnt_in = CNT_W'(MAX_DIGITS + 1);
            end
         end
         if (cmd.add_frac) begin
            if (frac_cnt_ff < CNT_W'(MAX_DIGITS)) begin
               frac_acc_in = (frac_acc_ff << 3) + (frac_acc_ff << 1) +
                             ACC_W'(digit_val);
               frac_cnt_in = frac_cnt_ff + CNT_W'(1);
            end else begin
               frac_cnt_in = CNT_W'(MAX_DIGITS + 1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sign_ff     <= 1'b0;
         int_acc_ff  <= '0;
         int_cnt_ff  <= '0;
         frac_acc_ff <= '0;
         frac_cnt_ff <= '0;
      end else begin
         sign_ff     <= sign_in;
         int_acc_ff  <= int_acc_in;
         int_cnt_ff  <= int_cnt_in;
         frac_acc_ff <= frac_acc_in;
         frac_cnt_ff <= frac_cnt_in;
      end
   end

   // Error classification; the integer error wins over the fraction error.
   always_comb begin
      if (int_cnt_ff > CNT_W'(MAX_DIGITS) || int_acc_ff >= INT_LIMIT) begin
         err_calc = ERR_INT;
      end else if (frac_cnt_ff > CNT_W'(MAX_DIGITS)) begin
         err_calc = ERR_FRAC;
      end else begin
         err_calc = ERR_NONE;
      end
   end

   // Snapshot of the literal at its terminating character.
   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         w_sign_ff <= sign_ff;
         w_int_ff  <= int_acc_ff;
         w_frac_ff <= frac_acc_ff;
         w_fcnt_ff <= frac_cnt_ff;
         w_err_ff  <= err_calc;
      end
   end

   // Byte exponent, alignment shift and the rounded numerator.
   always_comb begin
      blen     = bit_len(w_int_ff);
      expo_sum = {1'b0, blen} + (STEP_W+1)'(2);
      if (expo_sum[STEP_W:3] > 3'd3) begin
         expo_calc = 2'd3;
      end else begin
         expo_calc = expo_sum[4:3];
      end
      shamt    = {~expo_calc, 3'b000};
      div_calc = pow10(w_fcnt_ff);
      num_calc = (NUM_W'(w_frac_ff) << shamt) + NUM_W'(div_calc >> 1);
   end

   // One restoring division step: one quotient bit a cycle.
   always_comb begin
      rem_sh   = {rem_ff, low_ff[QUO_W-1]};
      rem_diff = rem_sh - {1'b0, div_ff};
      rem_ge   = (rem_sh >= {1'b0, div_ff});
      rem_in   = rem_ge ? rem_diff[ACC_W-1:0] : rem_sh[ACC_W-1:0];
      low_in   = {low_ff[QUO_W-2:0], rem_ge};
   end

   always_ff @(posedge clock) begin
      if (cmd.setup) begin
         expo_ff <= expo_calc;
         base_ff <= MANT_W'(w_int_ff) << shamt;
         div_ff  <= div_calc;
         rem_ff  <= num_calc[NUM_W-1:QUO_W];
         low_ff  <= num_calc[QUO_W-1:0];
         step_ff <= '0;
      end else if (cmd.step) begin
         rem_ff  <= rem_in;
         low_ff  <= low_in;
         step_ff <= step_ff + STEP_W'(1);
      end
   end

   // Result register: valid is control, the payload holds until reloaded.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.load_out) begin
         out_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         out_neg_ff <= w_sign_ff;
         out_err_ff <= w_err_ff;
         if (w_err_ff == ERR_NONE) begin
            out_expo_ff <= expo_ff;
            out_mant_ff <= base_ff + MANT_W'(low_ff);
         end else begin
            out_expo_ff <= '0;
            out_mant_ff <= '0;
         end
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_negative      = out_neg_ff;
   assign rsp_byte_exponent = out_expo_ff;
   assign rsp_mantissa      = out_mant_ff;
   assign rsp_error_code    = out_err_ff;

endmodule

`default_nettype wire

// ===== sv/decimal_to_qfp32_parser.sv =====
// ---------------------------------------------------------------------------
// decimal_to_qfp32_parser
// Parses a decimal literal, one ASCII character per word, into a sign, a
// byte exponent and a rounded 32-bit mantissa with an error code.
// ---------------------------------------------------------------------------
// Usage:
// The request channel carries one character per word on req_ch. A literal
// is an optional leading '-', integer digits, an optional '.' and fraction
// digits. Any other character ends the literal; it is consumed and one
// result word is produced on the response channel.
// Digits, the sign and the point are taken one per cycle. The terminating
// character starts a finishing sequence: a setup step, the bit-serial
// restoring divider that rounds the fraction, and the load of the result
// register. req_stall is high throughout that sequence.
// If the receiver stalls, the result register holds its word; the next
// literal may be taken meanwhile, but its own result waits in the load
// cycle until the register is free.
// Reset clears the parser to the start of a literal and empties the result
// register.
// ---------------------------------------------------------------------------
`default_nettype none

module decimal_to_qfp32_parser (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [7:0]  req_ch,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic             rsp_negative,
   output logic [1:0]       rsp_byte_exponent,
   output logic [31:0]      rsp_mantissa,
   output logic [1:0]       rsp_error_code
);
   import dqp_pkg::*;

   cmd_type    cmd;
   status_type status;

   // Grammar and sequencing.
   dqp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // Accumulators, divider and result register.
   dqp_dpath u_dpath (
      .clock             (clock),
      .reset             (reset),
      .req_ch            (req_ch),
      .cmd               (cmd),
      .status            (status),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_negative      (rsp_negative),
      .rsp_byte_exponent (rsp_byte_exponent),
      .rsp_mantissa      (rsp_mantissa),
      .rsp_error_code    (rsp_error_code)
   );

endmodule

`default_nettype wire
